/* rtl/sahg_pkg.sv */
// Shared types, constants and helpers of the stereo high-pass, low-pass and gain chain.
package sahg_pkg;

	localparam int WORD_W   = 32;
	localparam int SAMPLE_W = 24;
	localparam int ST_W     = 42;
	localparam int OP_W     = 43;
	localparam int COEF_W   = 16;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = COEF_W + 1 + OP_W;
	localparam int ACC_W    = PROD_W - FRAC_W;
	localparam int GAIN_SH  = 30;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_HP_COEFF = 3'd0;
	localparam logic [IDX_W-1:0] REG_LP_COEFF = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_Q   = 3'd2;
	localparam logic [IDX_W-1:0] REG_HP_ON    = 3'd3;
	localparam logic [IDX_W-1:0] REG_LP_ON    = 3'd4;
	localparam logic [IDX_W-1:0] REG_MONO     = 3'd5;

	localparam logic [COEF_W-1:0] GAIN_RESET = 16'd13107;

	typedef struct packed {
		logic [COEF_W-1:0] hp_coeff;
		logic [COEF_W-1:0] lp_coeff;
		logic [COEF_W-1:0] gain_q;
		logic              hp_on;
		logic              lp_on;
		logic              mono_mode;
	} cfg_t;

	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
		logic hi_same;
		hi_same = (v[ACC_W-1:ST_W-1] == {(ACC_W-ST_W+1){1'b0}}) ||
		          (v[ACC_W-1:ST_W-1] == {(ACC_W-ST_W+1){1'b1}});
		if (hi_same) begin
			return v[ST_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(ST_W-1){1'b0}}};
		end else begin
			return {1'b0, {(ST_W-1){1'b1}}};
		end
	endfunction

endpackage

/* rtl/sahg_if.sv */
// Frame input and result output channel interfaces.
interface sahg_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 clear_state;
	logic signed [sahg_pkg::WORD_W-1:0]   left_word;
	logic signed [sahg_pkg::WORD_W-1:0]   right_word;

	modport source(output valid, clear_state, left_word, right_word, input ready);
	modport sink(input valid, clear_state, left_word, right_word, output ready);
endinterface

interface sahg_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sahg_pkg::WORD_W-1:0]   left_out;
	logic signed [sahg_pkg::WORD_W-1:0]   right_out;
	logic                                 right_valid;

	modport source(output valid, left_out, right_out, right_valid, input ready);
	modport sink(input valid, left_out, right_out, right_valid, output ready);
endinterface

/* rtl/stereo_audio_hp_lp_gain_chain.sv */
// Stereo first-order high-pass, low-pass and gain chain on one shared 17x43 multiplier.
// Sequence per channel: a load state, then a multiply and a writeback state for each active
// stage (high-pass, low-pass, gain), then one output state per frame; mono skips the right.
// A new frame is accepted only in idle, after the last result is registered for output.
// Reset: asynchronous, clears control, filter history to zero, registers to their defaults.
module stereo_audio_hp_lp_gain_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sahg_pkg::ADDR_W-1:0]   paddr,
	input  logic [sahg_pkg::DATA_W-1:0]   pwdata,
	output logic [sahg_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	sahg_in_if.sink                       frame_in,
	sahg_out_if.source                    frame_out
);
	import sahg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_WB   = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [1:0] STG_HP = 2'd0;
	localparam logic [1:0] STG_LP = 2'd1;
	localparam logic [1:0] STG_GN = 2'd2;

	cfg_t cfg;

	sahg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [2:0]                  state_q;
	logic [1:0]                  stg_q;
	logic                        ch_q;
	logic signed [SAMPLE_W-1:0]  lx_q;
	logic signed [SAMPLE_W-1:0]  rx_q;
	logic [COEF_W-1:0]           coef_q;
	logic signed [OP_W-1:0]      opb_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [SAMPLE_W-1:0]  hp_x_q [2];
	logic signed [ST_W-1:0]      hp_y_q [2];
	logic signed [ST_W-1:0]      lp_y_q [2];
	logic signed [WORD_W-1:0]    left_q;
	logic signed [WORD_W-1:0]    right_q;
	logic                        out_valid_q;
	logic signed [WORD_W-1:0]    out_left_q;
	logic signed [WORD_W-1:0]    out_right_q;
	logic                        out_rv_q;

	logic                        accept;
	logic                        out_take;
	logic signed [SAMPLE_W-1:0]  x;
	logic signed [SAMPLE_W:0]    dx;
	logic signed [OP_W-1:0]      xq;
	logic signed [OP_W-1:0]      hp_s;
	logic signed [OP_W-1:0]      lp_y_ext;
	logic signed [PROD_W-1:0]    lp_y_sh;
	logic signed [ST_W-1:0]      y_hp;
	logic signed [ST_W-1:0]      y_lp;
	logic signed [PROD_W-1:0]    lp_acc;
	logic signed [PROD_W-1:0]    rnd;
	logic signed [WORD_W-1:0]    g_res;
	logic signed [PROD_W-1:0]    prod;
	logic [1:0]                  nxt_stg;
	logic [COEF_W-1:0]           nxt_coef;
	logic signed [OP_W-1:0]      nxt_opb;

	assign frame_in.ready  = (state_q == S_IDLE);
	assign accept          = frame_in.valid & frame_in.ready;
	assign out_take        = frame_out.valid & frame_out.ready;
	assign frame_out.valid       = out_valid_q;
	assign frame_out.left_out    = out_left_q;
	assign frame_out.right_out   = out_right_q;
	assign frame_out.right_valid = out_rv_q;

	assign x        = ch_q ? rx_q : lx_q;
	assign dx       = {x[SAMPLE_W-1], x} - {hp_x_q[ch_q][SAMPLE_W-1], hp_x_q[ch_q]};
	assign xq       = {{(OP_W-SAMPLE_W-FRAC_W){x[SAMPLE_W-1]}}, x, {FRAC_W{1'b0}}};
	assign hp_s     = {hp_y_q[ch_q][ST_W-1], hp_y_q[ch_q]} +
	                  {{(OP_W-SAMPLE_W-1-FRAC_W){dx[SAMPLE_W]}}, dx, {FRAC_W{1'b0}}};
	assign lp_y_ext = {lp_y_q[ch_q][ST_W-1], lp_y_q[ch_q]};
	assign lp_y_sh  = {{(PROD_W-ST_W-FRAC_W){lp_y_q[ch_q][ST_W-1]}}, lp_y_q[ch_q],
	                   {FRAC_W{1'b0}}};

	assign y_hp   = sat_st(prod_q[PROD_W-1:FRAC_W]);
	assign lp_acc = prod_q + lp_y_sh;
	assign y_lp   = sat_st(lp_acc[PROD_W-1:FRAC_W]);
	assign rnd    = prod_q + {{(PROD_W-GAIN_SH){1'b0}}, {GAIN_SH{prod_q[PROD_W-1]}}};
	assign g_res  = {{(WORD_W-PROD_W+GAIN_SH){rnd[PROD_W-1]}}, rnd[PROD_W-1:GAIN_SH]};
	assign prod   = $signed({1'b0, coef_q}) * opb_q;

	// Pick the next operation and its operands after a load or a writeback.
	always_comb begin
		nxt_stg  = STG_GN;
		nxt_coef = cfg.gain_q;
		nxt_opb  = xq;
		if (state_q == S_LOAD) begin
			priority if (cfg.hp_on) begin
				nxt_stg  = STG_HP;
				nxt_coef = cfg.hp_coeff;
				nxt_opb  = hp_s;
			end else if (cfg.lp_on) begin
				nxt_stg  = STG_LP;
				nxt_coef = cfg.lp_coeff;
				nxt_opb  = xq - lp_y_ext;
			end else begin
				nxt_stg  = STG_GN;
				nxt_coef = cfg.gain_q;
				nxt_opb  = xq;
			end
		end else if (stg_q == STG_HP) begin
			if (cfg.lp_on) begin
				nxt_stg  = STG_LP;
				nxt_coef = cfg.lp_coeff;
				nxt_opb  = {y_hp[ST_W-1], y_hp} - lp_y_ext;
			end else begin
				nxt_stg  = STG_GN;
				nxt_coef = cfg.gain_q;
				nxt_opb  = {y_hp[ST_W-1], y_hp};
			end
		end else begin
			nxt_stg  = STG_GN;
			nxt_coef = cfg.gain_q;
			nxt_opb  = {y_lp[ST_W-1], y_lp};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stg_q       <= STG_GN;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				hp_x_q[i] <= '0;
				hp_y_q[i] <= '0;
				lp_y_q[i] <= '0;
			end
		end else begin
			if (state_q == S_DONE && (!out_valid_q || frame_out.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q    <= 1'b0;
						state_q <= S_LOAD;
						if (frame_in.clear_state) begin
							for (int i = 0; i < 2; i++) begin
								hp_x_q[i] <= '0;
								hp_y_q[i] <= '0;
								lp_y_q[i] <= '0;
							end
						end
					end
				end
				S_LOAD: begin
					if (cfg.hp_on) begin
						hp_x_q[ch_q] <= x;
					end
					stg_q   <= nxt_stg;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_WB;
				end
				S_WB: begin
					unique case (stg_q)
						STG_HP: begin
							hp_y_q[ch_q] <= y_hp;
							stg_q        <= nxt_stg;
							state_q      <= S_MUL;
						end
						STG_LP: begin
							lp_y_q[ch_q] <= y_lp;
							stg_q        <= nxt_stg;
							state_q      <= S_MUL;
						end
						default: begin
							if (!ch_q && !cfg.mono_mode) begin
								ch_q    <= 1'b1;
								state_q <= S_LOAD;
							end else begin
								state_q <= S_DONE;
							end
						end
					endcase
				end
				S_DONE: begin
					if (!out_valid_q || frame_out.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: operands, product, channel results and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			lx_q <= frame_in.left_word[WORD_W-1:WORD_W-SAMPLE_W];
			rx_q <= frame_in.right_word[WORD_W-1:WORD_W-SAMPLE_W];
		end
		if (state_q == S_LOAD || (state_q == S_WB && stg_q != STG_GN)) begin
			coef_q <= nxt_coef;
			opb_q  <= nxt_opb;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod;
		end
		if (state_q == S_WB && stg_q == STG_GN) begin
			if (!ch_q) begin
				left_q <= g_res;
			end else begin
				right_q <= g_res;
			end
		end
		if (state_q == S_DONE && (!out_valid_q || frame_out.ready)) begin
			out_left_q  <= left_q;
			out_right_q <= cfg.mono_mode ? '0 : right_q;
			out_rv_q    <= !cfg.mono_mode;
		end
	end

endmodule

/* rtl/sahg_regs.sv */
// APB configuration register bank.
module sahg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sahg_pkg::ADDR_W-1:0]   paddr,
	input  logic [sahg_pkg::DATA_W-1:0]   pwdata,
	output logic [sahg_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output sahg_pkg::cfg_t                cfg
);
	import sahg_pkg::*;

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hp_coeff  <= '0;
			cfg_q.lp_coeff  <= '0;
			cfg_q.gain_q    <= GAIN_RESET;
			cfg_q.hp_on     <= 1'b0;
			cfg_q.lp_on     <= 1'b0;
			cfg_q.mono_mode <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_HP_COEFF: cfg_q.hp_coeff  <= pwdata[COEF_W-1:0];
				REG_LP_COEFF: cfg_q.lp_coeff  <= pwdata[COEF_W-1:0];
				REG_GAIN_Q:   cfg_q.gain_q    <= pwdata[COEF_W-1:0];
				REG_HP_ON:    cfg_q.hp_on     <= pwdata[0];
				REG_LP_ON:    cfg_q.lp_on     <= pwdata[0];
				REG_MONO:     cfg_q.mono_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_HP_COEFF: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_q.hp_coeff};
			REG_LP_COEFF: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_q.lp_coeff};
			REG_GAIN_Q:   prdata = {{(DATA_W-COEF_W){1'b0}}, cfg_q.gain_q};
			REG_HP_ON:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.hp_on};
			REG_LP_ON:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.lp_on};
			REG_MONO:     prdata = {{(DATA_W-1){1'b0}}, cfg_q.mono_mode};
			default:      prdata = '0;
		endcase
	end

endmodule
